FILE: rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master event sequencer.
// This package has no dependencies. Every module in the block but i2cms_ram imports it.
package i2cms_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_INDEX = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_LENGTH = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_READ_MODE = 8'd3;

  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [7:0] ST_BUS_ERROR = 8'h00;
  localparam logic [7:0] ST_START = 8'h08;
  localparam logic [7:0] ST_RESTART = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  localparam logic [1:0] XS_IDLE = 2'd0;
  localparam logic [1:0] XS_WRITING = 2'd1;
  localparam logic [1:0] XS_SUCCESS = 2'd2;
  localparam logic [1:0] XS_BUS_ERROR = 2'd3;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] register_index;
    logic [6:0] transfer_length;
    logic       read_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] status_code;
    logic [7:0] rx_data;
    logic [5:0] load_slot;
    logic [7:0] load_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       set_start;
    logic       clear_start;
    logic       set_stop;
    logic       set_ack;
    logic       rx_valid;
    logic [5:0] rx_slot;
    logic [7:0] rx_byte;
    logic [1:0] xfer_status;
    logic       found_flag;
    logic       done_flag;
  } out_t;

  typedef struct packed {
    logic [1:0] xfer_status;
    logic       found;
    logic       done;
  } flags_t;

endpackage

FILE: rtl/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies. A read at the address being written returns the old data.
module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/i2cms_step.sv
// Combinational transfer logic: decodes one transaction against the current state.
// Depends on i2cms_pkg for the payload, configuration and flag types.
module i2cms_step #(
  parameter int BUF_DEPTH = 64,
  localparam int PW = $clog2(BUF_DEPTH + 1),
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  i2cms_pkg::cfg_t   cfg,
  input  i2cms_pkg::in_t    item,
  input  logic [PW-1:0]     pos,
  input  i2cms_pkg::flags_t flags,
  input  logic [7:0]        head_byte,
  output i2cms_pkg::out_t   result,
  output logic [PW-1:0]     pos_next,
  output i2cms_pkg::flags_t flags_next,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data
);
  import i2cms_pkg::*;

  logic pos_in_buf;
  logic pos_below_limit;

  assign pos_in_buf = 32'(pos) < BUF_DEPTH;
  assign pos_below_limit = pos_in_buf && (32'(pos) < 32'(cfg.transfer_length));

  assign wr_en = (item.op == OP_LOAD) && (32'(item.load_slot) < BUF_DEPTH);
  assign wr_addr = AW'(item.load_slot);
  assign wr_data = item.load_byte;

  always_comb begin
    logic data_sent;
    data_sent = 1'b0;
    result = '0;
    pos_next = pos;
    flags_next = flags;
    unique case (item.op)
      OP_LOAD: begin
      end
      OP_START: begin
        pos_next = '0;
        if (!cfg.read_mode) begin
          flags_next.xfer_status = XS_WRITING;
        end
        result.set_start = 1'b1;
      end
      OP_EVENT: begin
        unique case (item.status_code) inside
          ST_BUS_ERROR: begin
            flags_next.xfer_status = XS_BUS_ERROR;
            result.set_ack = 1'b1;
            result.set_stop = 1'b1;
          end
          ST_START, ST_RESTART: begin
            result.tx_byte = cfg.slave_address | {7'b0, cfg.read_mode};
            result.tx_valid = 1'b1;
          end
          ST_SLA_W_ACK, ST_SLA_W_NACK: begin
            if (item.status_code == ST_SLA_W_ACK) begin
              flags_next.found = 1'b1;
            end
            flags_next.done = 1'b1;
            result.clear_start = 1'b1;
            result.tx_byte = cfg.register_index;
            result.tx_valid = 1'b1;
          end
          ST_DATA_W_ACK, ST_DATA_W_NACK: begin
            if (item.status_code == ST_DATA_W_ACK) begin
              flags_next.found = 1'b1;
            end
            flags_next.done = 1'b1;
            data_sent = 1'b1;
          end
          ST_ARB_LOST: begin
            result.set_start = 1'b1;
          end
          ST_SLA_R_ACK: begin
            flags_next.found = 1'b1;
            flags_next.done = 1'b1;
            result.set_ack = 1'b1;
          end
          ST_SLA_R_NACK: begin
            flags_next.done = 1'b1;
          end
          ST_DATA_R_ACK, ST_DATA_R_NACK: begin
            if (pos_in_buf) begin
              result.rx_valid = 1'b1;
              result.rx_slot = 6'(pos);
              result.rx_byte = item.rx_data;
              if (item.status_code == ST_DATA_R_ACK) begin
                pos_next = pos + PW'(1);
              end
            end
            if (item.status_code == ST_DATA_R_ACK) begin
              result.set_ack = 1'b1;
            end else begin
              result.set_stop = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (data_sent) begin
          if (pos_below_limit) begin
            result.tx_byte = head_byte;
            result.tx_valid = 1'b1;
            pos_next = pos + PW'(1);
          end else begin
            flags_next.xfer_status = XS_SUCCESS;
            result.set_stop = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    result.xfer_status = flags_next.xfer_status;
    result.found_flag = flags_next.found;
    result.done_flag = flags_next.done;
  end

endmodule

FILE: rtl/i2c_master_event_sequencer_core.sv
// Top level of the I2C master event sequencer; depends on i2cms_pkg, i2cms_ram, i2cms_step.
// A result is registered into the output register when its transaction is accepted.
// Throughput: one transaction per cycle unless output is stalled, set by the single register
// stage after the decode logic; the write buffer RAM is read ahead at the next byte position.
// Reset clears configuration, position, status and flags and empties the output register.
// Write buffer contents are not cleared by reset.
module i2c_master_event_sequencer_core #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  i2cms_pkg::in_t                     in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output i2cms_pkg::out_t                    out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [i2cms_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import i2cms_pkg::*;

  localparam int PW = $clog2(BUF_DEPTH + 1);
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  cfg_t          cfg;
  flags_t        flags;
  flags_t        flags_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [PW-1:0] pos_ahead;
  out_t          result;
  logic          accept;
  logic          wr_en;
  logic          wr_req;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    head_byte;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  i2cms_step #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_step (
    .cfg        (cfg),
    .item       (in_item),
    .pos        (pos),
    .flags      (flags),
    .head_byte  (head_byte),
    .result     (result),
    .pos_next   (pos_next),
    .flags_next (flags_next),
    .wr_en      (wr_req),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  assign wr_en = accept && wr_req;
  assign pos_ahead = rst ? '0 : (accept ? pos_next : pos);
  assign rd_addr = pos_ahead[AW-1:0];
  assign head_byte = fwd_hit ? fwd_data : rd_data;

  i2cms_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    fwd_hit <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:   cfg.slave_address <= cfg_data[7:0];
        CFG_REGISTER_INDEX:  cfg.register_index <= cfg_data[7:0];
        CFG_TRANSFER_LENGTH: cfg.transfer_length <= cfg_data[6:0];
        CFG_READ_MODE:       cfg.read_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      flags <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      pos <= pos_next;
      flags <= flags_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

endmodule

FILE: rtl/i2cms_checker.sv
// Port-level checks for the I2C master event sequencer, bound to the top level.
// Depends on i2cms_pkg for the payload types.
module i2cms_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input i2cms_pkg::out_t out_item
);
  import i2cms_pkg::*;

  // A stalled result must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  // The output register must never block input while it is empty.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the output register is empty");

  // The done flag is sticky from one result to the next.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.done_flag ##1 out_valid |-> out_item.done_flag)
    else $error("done flag dropped between results");

  // A device found always implies a finished address phase.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_item.found_flag || out_item.done_flag)
    else $error("found flag without done flag");

  // A single status event never both sends and receives a byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.tx_valid && out_item.rx_valid))
    else $error("result sends and receives a byte at once");

endmodule

bind i2c_master_event_sequencer_core i2cms_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

FILE: dv/i2cms_tb_pkg.sv
// Scoreboard for the I2C master event sequencer testbench: predicts the action word for
// each accepted transaction and checks the block's results in order. Depends on i2cms_pkg.
`timescale 1ns / 100ps

package i2cms_tb_pkg;
  import i2cms_pkg::*;

  localparam int BUF_DEPTH = 64;
  localparam int CFG_COUNT = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class action_scoreboard;
    logic [7:0] write_store [BUF_DEPTH];
    bit         loaded [BUF_DEPTH];
    logic [6:0] byte_pos;
    logic [1:0] xfer_state;
    logic       found;
    logic       done;
    cfg_t       regs;
    out_t       pending_actions [$];
    int         errors;
    int         results_checked;

    function new();
      foreach (loaded[i]) begin
        loaded[i] = 1'b0;
        write_store[i] = 8'h00;
      end
      byte_pos = '0;
      xfer_state = XS_IDLE;
      found = 1'b0;
      done = 1'b0;
      regs = '0;
      errors = 0;
      results_checked = 0;
    endfunction

    function logic [6:0] write_limit();
      return (regs.transfer_length < BUF_DEPTH) ? regs.transfer_length : 7'(BUF_DEPTH);
    endfunction

    function bit next_write_unloaded();
      return (byte_pos < write_limit()) && !loaded[byte_pos[5:0]];
    endfunction

    function logic [5:0] next_write_slot();
      return byte_pos[5:0];
    endfunction

    function int pending();
      return pending_actions.size();
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SLAVE_ADDRESS:   regs.slave_address = data;
        CFG_REGISTER_INDEX:  regs.register_index = data;
        CFG_TRANSFER_LENGTH: regs.transfer_length = data[6:0];
        CFG_READ_MODE:       regs.read_mode = data[0];
        default: ;
      endcase
    endfunction

    function out_t predict_actions(in_t it);
      out_t r;
      bit   data_sent;
      r = '0;
      data_sent = 1'b0;
      case (it.op)
        OP_LOAD: begin
          if (it.load_slot < BUF_DEPTH) begin
            write_store[it.load_slot] = it.load_byte;
            loaded[it.load_slot] = 1'b1;
          end
        end
        OP_START: begin
          byte_pos = '0;
          if (!regs.read_mode) xfer_state = XS_WRITING;
          r.set_start = 1'b1;
        end
        OP_EVENT: begin
          case (it.status_code)
            ST_BUS_ERROR: begin
              xfer_state = XS_BUS_ERROR;
              r.set_ack = 1'b1;
              r.set_stop = 1'b1;
            end
            ST_START, ST_RESTART: begin
              r.tx_byte = regs.slave_address | {7'b0, regs.read_mode};
              r.tx_valid = 1'b1;
            end
            ST_SLA_W_ACK, ST_SLA_W_NACK: begin
              if (it.status_code == ST_SLA_W_ACK) found = 1'b1;
              done = 1'b1;
              r.clear_start = 1'b1;
              r.tx_byte = regs.register_index;
              r.tx_valid = 1'b1;
            end
            ST_DATA_W_ACK, ST_DATA_W_NACK: begin
              if (it.status_code == ST_DATA_W_ACK) found = 1'b1;
              done = 1'b1;
              data_sent = 1'b1;
            end
            ST_ARB_LOST: r.set_start = 1'b1;
            ST_SLA_R_ACK: begin
              found = 1'b1;
              done = 1'b1;
              r.set_ack = 1'b1;
            end
            ST_SLA_R_NACK: done = 1'b1;
            ST_DATA_R_ACK, ST_DATA_R_NACK: begin
              if (byte_pos < BUF_DEPTH) begin
                r.rx_valid = 1'b1;
                r.rx_slot = byte_pos[5:0];
                r.rx_byte = it.rx_data;
                if (it.status_code == ST_DATA_R_ACK) byte_pos = byte_pos + 7'd1;
              end
              if (it.status_code == ST_DATA_R_ACK) r.set_ack = 1'b1;
              else r.set_stop = 1'b1;
            end
            default: ;
          endcase
          if (data_sent) begin
            if (byte_pos < write_limit()) begin
              r.tx_byte = write_store[byte_pos[5:0]];
              r.tx_valid = 1'b1;
              byte_pos = byte_pos + 7'd1;
            end else begin
              xfer_state = XS_SUCCESS;
              r.set_stop = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.xfer_status = xfer_state;
      r.found_flag = found;
      r.done_flag = done;
      return r;
    endfunction

    function void note_item(in_t it);
      pending_actions.push_back(predict_actions(it));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
               results_checked, what, got, want);
      errors++;
    endtask

    task check_actions(out_t got);
      out_t want;
      if (pending_actions.size() == 0) begin
        report("result with no transaction waiting", got, 0);
      end else begin
        want = pending_actions.pop_front();
        results_checked++;
        if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
        if (got.tx_valid !== want.tx_valid) report("tx_valid", got.tx_valid, want.tx_valid);
        if (got.set_start !== want.set_start)
          report("set_start", got.set_start, want.set_start);
        if (got.clear_start !== want.clear_start)
          report("clear_start", got.clear_start, want.clear_start);
        if (got.set_stop !== want.set_stop) report("set_stop", got.set_stop, want.set_stop);
        if (got.set_ack !== want.set_ack) report("set_ack", got.set_ack, want.set_ack);
        if (got.rx_valid !== want.rx_valid) report("rx_valid", got.rx_valid, want.rx_valid);
        if (got.rx_slot !== want.rx_slot) report("rx_slot", got.rx_slot, want.rx_slot);
        if (got.rx_byte !== want.rx_byte) report("rx_byte", got.rx_byte, want.rx_byte);
        if (got.xfer_status !== want.xfer_status)
          report("xfer_status", got.xfer_status, want.xfer_status);
        if (got.found_flag !== want.found_flag)
          report("found_flag", got.found_flag, want.found_flag);
        if (got.done_flag !== want.done_flag)
          report("done_flag", got.done_flag, want.done_flag);
      end
    endtask
  endclass

endpackage

FILE: dv/tb_i2c_master_event_sequencer_core.sv
// Top of the I2C master event sequencer testbench: clock, reset, drivers and monitor.
// Directed transfers, then random phases of write and read transfers and noise under
// random stalls. Depends on i2cms_pkg, i2cms_tb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_i2c_master_event_sequencer_core;
  import i2cms_pkg::*;
  import i2cms_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_LIMIT = 5000;
  localparam logic [7:0] KNOWN_CODES [12] = '{
    ST_BUS_ERROR, ST_START, ST_RESTART, ST_SLA_W_ACK, ST_SLA_W_NACK, ST_DATA_W_ACK,
    ST_DATA_W_NACK, ST_ARB_LOST, ST_SLA_R_ACK, ST_SLA_R_NACK, ST_DATA_R_ACK, ST_DATA_R_NACK
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  action_scoreboard sb;
  cfg_t cur_cfg;
  bit   calm = 1'b0;
  int   cycles = 0;
  int   accepted_inputs = 0;
  int   cfg_accepts = 0;
  int   sent_items = 0;
  int   phases = 0;
  int   deep_reads = 0;

  i2c_master_event_sequencer_core #(.BUF_DEPTH(BUF_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycles, sb.pending());
      $display("tb_i2c_master_event_sequencer_core failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && out_ready) sb.check_actions(out_item);
      if (cfg_valid && cfg_ready) begin
        sb.write_register(cfg_index, cfg_data);
        cfg_accepts++;
      end
      if (in_valid && in_ready) begin
        sb.note_item(in_item);
        accepted_inputs++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  function automatic logic [7:0] pick_code();
    return KNOWN_CODES[$urandom_range(0, 11)];
  endfunction

  function automatic in_t event_item(logic [7:0] code);
    in_t it;
    it = in_t'($urandom);
    it.op = OP_EVENT;
    it.status_code = code;
    return it;
  endfunction

  function automatic in_t load_item(logic [5:0] slot, logic [7:0] value);
    in_t it;
    it = in_t'($urandom);
    it.op = OP_LOAD;
    it.load_slot = slot;
    it.load_byte = value;
    return it;
  endfunction

  function automatic in_t start_item();
    in_t it;
    it = in_t'($urandom);
    it.op = OP_START;
    return it;
  endfunction

  function automatic in_t noise_item();
    in_t it;
    it = in_t'($urandom);
    if ($urandom_range(0, 1)) it.status_code = pick_code();
    return it;
  endfunction

  task automatic drive_item(in_t it);
    int n;
    n = accepted_inputs;
    in_item <= it;
    in_valid <= 1'b1;
    if (it.op != OP_UNUSED) sent_items++;
    do @(negedge clk); while (accepted_inputs == n);
  endtask

  // A data-sent status must never make the block fetch a write store entry that was
  // never loaded, so such an entry is loaded just ahead of the status.
  task automatic send_item(in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (it.op == OP_EVENT && (it.status_code == ST_DATA_W_ACK ||
        it.status_code == ST_DATA_W_NACK) && sb.next_write_unloaded())
      drive_item(load_item(sb.next_write_slot(), 8'($urandom)));
    drive_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int n;
    n = cfg_accepts;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (cfg_accepts == n);
  endtask

  task automatic apply_config(cfg_t c);
    set_register(CFG_SLAVE_ADDRESS, c.slave_address);
    set_register(CFG_REGISTER_INDEX, c.register_index);
    set_register(CFG_TRANSFER_LENGTH, {1'($urandom_range(0, 1)), c.transfer_length});
    set_register(CFG_READ_MODE, {7'($urandom_range(0, 127)), c.read_mode});
    set_register(8'($urandom_range(CFG_COUNT, 255)), 8'($urandom));
    cfg_valid <= 1'b0;
    cur_cfg = c;
    phases++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    int   r;
    c.slave_address = 8'($urandom);
    c.register_index = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 65) c.transfer_length = 7'($urandom_range(0, 6));
    else if (r < 78) c.transfer_length = 7'(BUF_DEPTH);
    else if (r < 88) c.transfer_length = 7'h7F;
    else c.transfer_length = 7'($urandom_range(0, 127));
    c.read_mode = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic write_transfer();
    int lim;
    int nbytes;
    lim = (cur_cfg.transfer_length < BUF_DEPTH) ? cur_cfg.transfer_length : BUF_DEPTH;
    for (int s = 0; s < lim; s++)
      if ($urandom_range(0, 1)) send_item(load_item(6'(s), 8'($urandom)));
    send_item(start_item());
    send_item(event_item($urandom_range(0, 1) ? ST_START : ST_RESTART));
    send_item(event_item($urandom_range(0, 9) ? ST_SLA_W_ACK : ST_SLA_W_NACK));
    nbytes = $urandom_range(0, 6) ? lim + 1 : $urandom_range(0, lim + 1);
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 29) == 0) send_item(event_item(pick_code()));
      send_item(event_item($urandom_range(0, 6) ? ST_DATA_W_ACK : ST_DATA_W_NACK));
    end
    if ($urandom_range(0, 19) == 0) send_item(event_item(ST_BUS_ERROR));
  endtask

  task automatic read_transfer();
    int n;
    n = $urandom_range(0, 6) ? $urandom_range(0, 8) : $urandom_range(60, 70);
    if (n >= BUF_DEPTH) deep_reads++;
    send_item(start_item());
    send_item(event_item($urandom_range(0, 1) ? ST_START : ST_RESTART));
    send_item(event_item($urandom_range(0, 9) ? ST_SLA_R_ACK : ST_SLA_R_NACK));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) send_item(event_item(pick_code()));
      send_item(event_item(ST_DATA_R_ACK));
    end
    send_item(event_item(ST_DATA_R_NACK));
    if ($urandom_range(0, 4) == 0) send_item(event_item(ST_DATA_R_NACK));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) send_item(noise_item());
  endtask

  task automatic directed_part();
    in_t spare;
    apply_config('{slave_address: 8'hA4, register_index: 8'h5B,
                   transfer_length: 7'd3, read_mode: 1'b0});
    send_item(load_item(6'd0, 8'h00));
    send_item(load_item(6'd63, 8'hFF));
    send_item(load_item(6'd1, 8'hA5));
    send_item(load_item(6'd2, 8'h5A));
    spare = noise_item();
    spare.op = OP_UNUSED;
    send_item(spare);
    send_item(event_item(8'hFF));
    send_item(start_item());
    send_item(event_item(ST_START));
    send_item(event_item(ST_SLA_W_ACK));
    repeat (4) send_item(event_item(ST_DATA_W_ACK));
    send_item(event_item(ST_RESTART));
    send_item(event_item(ST_SLA_W_NACK));
    send_item(event_item(ST_DATA_W_NACK));
    send_item(event_item(ST_ARB_LOST));
    send_item(event_item(ST_BUS_ERROR));
    wait_idle();
    apply_config('{slave_address: 8'hFE, register_index: 8'hFF,
                   transfer_length: 7'h7F, read_mode: 1'b1});
    send_item(start_item());
    send_item(event_item(ST_START));
    send_item(event_item(ST_SLA_R_ACK));
    send_item(event_item(ST_SLA_R_NACK));
    spare = event_item(ST_DATA_R_ACK);
    spare.rx_data = 8'h00;
    send_item(spare);
    spare.rx_data = 8'hFF;
    send_item(spare);
    send_item(event_item(ST_DATA_R_NACK));
    wait_idle();
    apply_config('{slave_address: 8'h00, register_index: 8'h00,
                   transfer_length: 7'd0, read_mode: 1'b0});
    send_item(start_item());
    send_item(event_item(ST_DATA_W_ACK));
    wait_idle();
  endtask

  initial begin
    int goal;
    int r;
    int drain;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_part();
    goal = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      apply_config(random_config());
      repeat ($urandom_range(4, 10)) begin
        r = $urandom_range(0, 99);
        if (r < 25) noise_burst();
        else if ((r < 80) == (cur_cfg.read_mode == 1'b0)) write_transfer();
        else read_transfer();
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);
    if (sb.pending() != 0) sb.report("results never delivered", sb.pending(), 0);
    $display("Summary: %0d transactions over %0d register settings, %0d results checked.",
             sent_items, phases, sb.results_checked);
    $display("Write and read transfers, bus errors, noise and %0d reads past the buffer end.",
             deep_reads);
    if (sb.errors == 0) begin
      $display("tb_i2c_master_event_sequencer_core passed");
    end else begin
      $display("tb_i2c_master_event_sequencer_core failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/i2cms_pkg.sv
rtl/i2cms_ram.sv
rtl/i2cms_step.sv
rtl/i2c_master_event_sequencer_core.sv
rtl/i2cms_checker.sv
dv/i2cms_tb_pkg.sv
dv/tb_i2c_master_event_sequencer_core.sv
